// File: src/mkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI keyboard split package
// Beat types, message kind codes, register indexes and sizes shared by the
// four-zone keyboard split and its key shift table.
// ----------------------------------------------------------------------------
package mkst_pkg;

  // Sizes of the message fields and of the key table.
  localparam int KEY_W     = 7;
  localparam int SHIFT_W   = 7;
  localparam int KEY_COUNT = 128;

  // Register widths.
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_INDEX_W = 3;
  localparam int ZCH_W       = 5;

  // Reset values of the configuration registers.
  localparam logic [3:0]  LISTEN_RST      = 4'd0;
  localparam logic [19:0] ZONE_CH_RST     = 20'd541200;
  localparam logic [7:0]  SPLIT_LOW_RST   = 8'd60;
  localparam logic [7:0]  SPLIT_MID_RST   = 8'd127;
  localparam logic [7:0]  SPLIT_HIGH_RST  = 8'd127;
  localparam logic [27:0] ZONE_SHIFT_RST  = 28'd0;

  // A split register at this value learns its split from the next note-on.
  localparam logic [7:0] LEARN_CODE = 8'd128;

  // Message kinds in the upper status nibble.
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_POLY     = 4'hA;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_CH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_MID  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_HIGH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_SHIFT = 3'd5;

  // Input beat: one three-byte MIDI message.
  typedef struct packed {
    logic [7:0]       status_byte;
    logic [KEY_W-1:0] data_one;
    logic [6:0]       data_two;
  } in_beat_t;

  // Result beat: the rewritten message.
  typedef struct packed {
    logic [7:0]       out_status;
    logic [KEY_W-1:0] out_data_one;
    logic [6:0]       out_data_two;
  } out_beat_t;

  // Update of the key shift table from the working stage.
  typedef struct packed {
    logic               set;
    logic               clr;
    logic [KEY_W-1:0]   key;
    logic [SHIFT_W-1:0] shift;
  } key_wr_t;

  // Stored shift for the key in the working stage.
  typedef struct packed {
    logic               held;
    logic [SHIFT_W-1:0] shift;
  } key_look_t;

endpackage

// File: src/mkst_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key shift table
// Remembers the transpose of each sounding key. The shift values live in a
// memory read when a beat is accepted; held flags are flip-flops cleared at
// reset. A write from the working stage at the same edge is forwarded.
// ----------------------------------------------------------------------------
module mkst_key_table #(
  parameter int KEY_COUNT = mkst_pkg::KEY_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [mkst_pkg::KEY_W-1:0]    rd_key,
  input  logic [mkst_pkg::KEY_W-1:0]    cur_key,
  input  mkst_pkg::key_wr_t             key_wr,
  output mkst_pkg::key_look_t           look
);

  localparam int IDX_W = $clog2(KEY_COUNT);

  logic [mkst_pkg::SHIFT_W-1:0] shift_mem [KEY_COUNT];
  logic [mkst_pkg::SHIFT_W-1:0] rd_data_r;
  logic [mkst_pkg::SHIFT_W-1:0] fwd_shift_r;
  logic                         fwd_hit_r;
  logic [KEY_COUNT-1:0]         held_r;
  logic [IDX_W-1:0]             rd_idx;
  logic [IDX_W-1:0]             cur_idx;
  logic [IDX_W-1:0]             wr_idx;

  assign rd_idx  = rd_key[IDX_W-1:0];
  assign cur_idx = cur_key[IDX_W-1:0];
  assign wr_idx  = key_wr.key[IDX_W-1:0];

  // Shift memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_wr.set) begin
      shift_mem[wr_idx] <= key_wr.shift;
    end
    if (rd_en) begin
      rd_data_r <= shift_mem[rd_idx];
    end
  end

  // Forward a write to the same key that lands at the read edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= key_wr.set && (key_wr.key == rd_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_shift_r <= key_wr.shift;
    end
  end

  // Held flags, one per key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (key_wr.set) begin
      held_r[wr_idx] <= 1'b1;
    end else if (key_wr.clr) begin
      held_r[wr_idx] <= 1'b0;
    end
  end

  assign look.held  = held_r[cur_idx];
  assign look.shift = fwd_hit_r ? fwd_shift_r : rd_data_r;

  // A note-on leaves its key held.
  a_set_holds: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr.set |=> held_r[$past(wr_idx)])
    else $error("key not held after note-on");

  // A note-off leaves its key released.
  a_clr_frees: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr.clr && !key_wr.set |=> !held_r[$past(wr_idx)])
    else $error("key still held after note-off");

  // Set and clear never come together.
  a_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(key_wr.set && key_wr.clr))
    else $error("key table set and clear in one cycle");

endmodule

// File: src/midi_keyboard_split_transposer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-zone MIDI keyboard split with transpose
// Sorts note messages on one channel into four key zones, rewrites their
// channel and transposes their key, remembering the shift per sounding key.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall / in_data) carry one three-byte MIDI
//   message each; result beats (out_valid / out_stall / out_data) carry the
//   rewritten message, exactly one per input beat, in order.
//   Registers are written through cfg_wr_en / cfg_index / cfg_data while no
//   beat is in flight; index 0 listen channel, 1 zone channels, 2..4 split
//   points, 5 zone transposes. Other indexes are ignored.
//   A beat passes from acceptance into the working stage register and then
//   the output register. One beat is accepted every cycle while in_stall is
//   low; the key shift table is read at acceptance and written as the beat
//   leaves the working stage, with a forward path between neighbors.
//   While out_stall is high the output beat holds; the working stage keeps
//   one more beat and in_stall rises only when both are occupied.
//   Reset restores the register defaults, releases every key and forgets
//   learned splits; beats are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
module midi_keyboard_split_transposer #(
  parameter int KEY_COUNT = mkst_pkg::KEY_COUNT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mkst_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mkst_pkg::out_beat_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [mkst_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mkst_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [3:0]  listen_r;
  logic [19:0] zone_ch_r;
  logic [7:0]  split_low_r;
  logic [7:0]  split_mid_r;
  logic [7:0]  split_high_r;
  logic [27:0] zone_shift_r;

  // Learned split points.
  logic                      lrn_low_vld_r, lrn_mid_vld_r, lrn_high_vld_r;
  logic [mkst_pkg::KEY_W-1:0] lrn_low_r, lrn_mid_r, lrn_high_r;
  logic                      lrn_low_vld_nxt, lrn_mid_vld_nxt, lrn_high_vld_nxt;
  logic [mkst_pkg::KEY_W-1:0] lrn_low_nxt, lrn_mid_nxt, lrn_high_nxt;

  // Pipeline.
  logic                 s1_valid_r;
  mkst_pkg::in_beat_t   s1_beat_r;
  logic                 out_valid_r;
  mkst_pkg::out_beat_t  out_beat_r;
  logic                 in_accept;
  logic                 s1_fire;

  // Working stage signals.
  logic [3:0]                   kind;
  logic [3:0]                   eff_kind;
  logic [3:0]                   chan;
  logic [mkst_pkg::KEY_W-1:0]   key;
  logic                         handled;
  logic                         is_on;
  logic                         is_off;
  logic [7:0]                   split0, split1, split2;
  logic [1:0]                   zone;
  logic [mkst_pkg::ZCH_W-1:0]   zch;
  logic [mkst_pkg::SHIFT_W-1:0] zshift;
  logic [3:0]                   new_chan;
  logic [mkst_pkg::KEY_W-1:0]   new_key;
  mkst_pkg::out_beat_t          res_beat;
  mkst_pkg::key_wr_t            key_wr;
  mkst_pkg::key_look_t          look;
  logic                         learn;

  // Add a signed shift to a key and clamp to the key range.
  function automatic logic [mkst_pkg::KEY_W-1:0] clamp_key(
    input logic [mkst_pkg::KEY_W-1:0]   k,
    input logic [mkst_pkg::SHIFT_W-1:0] sh
  );
    logic signed [mkst_pkg::KEY_W+1:0] sum;
    sum = $signed({2'b00, k}) + $signed({{2{sh[mkst_pkg::SHIFT_W-1]}}, sh});
    if (sum < 0) begin
      clamp_key = '0;
    end else if (sum > $signed(10'sd127)) begin
      clamp_key = '1;
    end else begin
      clamp_key = sum[mkst_pkg::KEY_W-1:0];
    end
  endfunction

  // Handshake.
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_beat_r <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_beat_r <= res_beat;
    end
  end

  // Message decode; a note-on with zero velocity is a note-off.
  always_comb begin
    kind     = s1_beat_r.status_byte[7:4];
    chan     = s1_beat_r.status_byte[3:0];
    key      = s1_beat_r.data_one;
    eff_kind = (kind == mkst_pkg::KIND_NOTE_ON && s1_beat_r.data_two == '0) ?
               mkst_pkg::KIND_NOTE_OFF : kind;
    is_on    = eff_kind == mkst_pkg::KIND_NOTE_ON;
    is_off   = eff_kind == mkst_pkg::KIND_NOTE_OFF;
    handled  = (chan == listen_r) &&
               (is_on || is_off || eff_kind == mkst_pkg::KIND_POLY);
  end

  // Effective split points and zone choice.
  always_comb begin
    split0 = (split_low_r == mkst_pkg::LEARN_CODE && lrn_low_vld_r) ?
             {1'b0, lrn_low_r} : split_low_r;
    split1 = (split_mid_r == mkst_pkg::LEARN_CODE && lrn_mid_vld_r) ?
             {1'b0, lrn_mid_r} : split_mid_r;
    split2 = (split_high_r == mkst_pkg::LEARN_CODE && lrn_high_vld_r) ?
             {1'b0, lrn_high_r} : split_high_r;
    if ({1'b0, key} < split0) begin
      zone = 2'd0;
    end else if ({1'b0, key} < split1) begin
      zone = 2'd1;
    end else if ({1'b0, key} < split2) begin
      zone = 2'd2;
    end else begin
      zone = 2'd3;
    end
  end

  // Zone output channel and transpose.
  always_comb begin
    case (zone)
      2'd0: begin
        zch    = zone_ch_r[4:0];
        zshift = zone_shift_r[6:0];
      end
      2'd1: begin
        zch    = zone_ch_r[9:5];
        zshift = zone_shift_r[13:7];
      end
      2'd2: begin
        zch    = zone_ch_r[14:10];
        zshift = zone_shift_r[20:14];
      end
      default: begin
        zch    = zone_ch_r[19:15];
        zshift = zone_shift_r[27:21];
      end
    endcase
    new_chan = zch[mkst_pkg::ZCH_W-1] ? chan : zch[3:0];
  end

  // Key rewrite: a note-off of a held key takes the shift stored at its note-on.
  always_comb begin
    if (is_off) begin
      new_key = look.held ? clamp_key(key, look.shift) : key;
    end else begin
      new_key = clamp_key(key, zshift);
    end
    res_beat.out_data_two = s1_beat_r.data_two;
    if (handled) begin
      res_beat.out_status   = {eff_kind, new_chan};
      res_beat.out_data_one = new_key;
    end else begin
      res_beat.out_status   = s1_beat_r.status_byte;
      res_beat.out_data_one = key;
    end
  end

  // Key table update as the beat leaves the working stage.
  always_comb begin
    key_wr.set   = s1_fire && handled && is_on;
    key_wr.clr   = s1_fire && handled && is_off;
    key_wr.key   = key;
    key_wr.shift = zshift;
  end

  mkst_key_table #(
    .KEY_COUNT (KEY_COUNT)
  ) u_key_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_key  (in_data.data_one),
    .cur_key (key),
    .key_wr  (key_wr),
    .look    (look)
  );

  // Split learning: a note-on fills every split waiting in learn mode.
  assign learn = s1_fire && handled && is_on;

  always_comb begin
    lrn_low_vld_nxt  = lrn_low_vld_r;
    lrn_mid_vld_nxt  = lrn_mid_vld_r;
    lrn_high_vld_nxt = lrn_high_vld_r;
    lrn_low_nxt      = lrn_low_r;
    lrn_mid_nxt      = lrn_mid_r;
    lrn_high_nxt     = lrn_high_r;
    if (learn && split_low_r == mkst_pkg::LEARN_CODE && !lrn_low_vld_r) begin
      lrn_low_vld_nxt = 1'b1;
      lrn_low_nxt     = key;
    end
    if (learn && split_mid_r == mkst_pkg::LEARN_CODE && !lrn_mid_vld_r) begin
      lrn_mid_vld_nxt = 1'b1;
      lrn_mid_nxt     = key;
    end
    if (learn && split_high_r == mkst_pkg::LEARN_CODE && !lrn_high_vld_r) begin
      lrn_high_vld_nxt = 1'b1;
      lrn_high_nxt     = key;
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        mkst_pkg::CFG_SPLIT_LOW:  lrn_low_vld_nxt  = 1'b0;
        mkst_pkg::CFG_SPLIT_MID:  lrn_mid_vld_nxt  = 1'b0;
        mkst_pkg::CFG_SPLIT_HIGH: lrn_high_vld_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrn_low_vld_r  <= 1'b0;
      lrn_mid_vld_r  <= 1'b0;
      lrn_high_vld_r <= 1'b0;
    end else begin
      lrn_low_vld_r  <= lrn_low_vld_nxt;
      lrn_mid_vld_r  <= lrn_mid_vld_nxt;
      lrn_high_vld_r <= lrn_high_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lrn_low_r  <= lrn_low_nxt;
    lrn_mid_r  <= lrn_mid_nxt;
    lrn_high_r <= lrn_high_nxt;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r     <= mkst_pkg::LISTEN_RST;
      zone_ch_r    <= mkst_pkg::ZONE_CH_RST;
      split_low_r  <= mkst_pkg::SPLIT_LOW_RST;
      split_mid_r  <= mkst_pkg::SPLIT_MID_RST;
      split_high_r <= mkst_pkg::SPLIT_HIGH_RST;
      zone_shift_r <= mkst_pkg::ZONE_SHIFT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mkst_pkg::CFG_LISTEN:     listen_r     <= cfg_data[3:0];
        mkst_pkg::CFG_ZONE_CH:    zone_ch_r    <= cfg_data[19:0];
        mkst_pkg::CFG_SPLIT_LOW:  split_low_r  <= cfg_data[7:0];
        mkst_pkg::CFG_SPLIT_MID:  split_mid_r  <= cfg_data[7:0];
        mkst_pkg::CFG_SPLIT_HIGH: split_high_r <= cfg_data[7:0];
        mkst_pkg::CFG_ZONE_SHIFT: zone_shift_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // The input side stalls only behind a full working stage.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  // A new result beat appears only after the working stage handed one over.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire))
    else $error("result beat without a source");

  // A learned split exists only while its register holds the learn code; checked here for the low and high splits.
  a_learn_low: assert property (@(posedge clk) disable iff (!rst_n)
    lrn_low_vld_r |-> split_low_r == mkst_pkg::LEARN_CODE)
    else $error("learned low split without learn code");

  a_learn_high: assert property (@(posedge clk) disable iff (!rst_n)
    lrn_high_vld_r |-> split_high_r == mkst_pkg::LEARN_CODE)
    else $error("learned high split without learn code");

endmodule
